// ===== hdl/vt44_pkg.sv =====
// Package for the 4x4 vertex transform core: beat structs, stage types and
// register map constants. No dependencies.
package vt44_pkg;

  localparam int unsigned DATA_W   = 32;                 // Q format word
  localparam int unsigned PROD_W   = 2 * DATA_W;         // full product
  localparam int unsigned SUM_W    = PROD_W + 2;         // four products, exact
  localparam int unsigned NUM_ROWS = 4;
  localparam int unsigned NUM_ENT  = NUM_ROWS * NUM_ROWS;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_W    = 64;
  localparam int unsigned ADDR_W   = 6;                  // 8 regs at 8-byte stride
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned IDX_LSB  = 3;

  // matrix register indexes, two entries per register
  typedef enum logic [IDX_W-1:0] {
    REG_MAT_01, REG_MAT_23, REG_MAT_45, REG_MAT_67,
    REG_MAT_89, REG_MAT_1011, REG_MAT_1213, REG_MAT_1415
  } mat_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] vec_x;
    logic signed [DATA_W-1:0] vec_y;
    logic signed [DATA_W-1:0] vec_z;
    logic signed [DATA_W-1:0] vec_w;
    logic                     point_mode;
  } vt_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic signed [DATA_W-1:0] out_w;
    logic                     saturated;
  } vt_out_t;

  // column-major: entry k is matrix row k%4, column k/4
  typedef logic [NUM_ENT-1:0][DATA_W-1:0]                 mat_t;
  typedef logic [NUM_ROWS-1:0][NUM_ROWS-1:0][PROD_W-1:0]  prod_set_t;
  typedef logic [NUM_ROWS-1:0][SUM_W-1:0]                 sum_set_t;

  // handshake between neighbouring stages
  typedef struct packed {
    logic valid;
  } stg_fwd_t;

  typedef struct packed {
    logic ready;
  } stg_bwd_t;

endpackage

// ===== hdl/vt44_cfg_regs.sv =====
// Matrix register file behind the APB-style configuration port.
// Depends on vt44_pkg.
module vt44_cfg_regs #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [vt44_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [vt44_pkg::REG_W-1:0]   cfg_pwdata,
  output logic [vt44_pkg::REG_W-1:0]   cfg_prdata,
  output logic                         cfg_pready,
  output vt44_pkg::mat_t               mat
);

  localparam logic [vt44_pkg::REG_W-1:0] ONE_LO = vt44_pkg::REG_W'(64'd1 << FRAC_BITS);
  localparam logic [vt44_pkg::REG_W-1:0] ONE_HI = ONE_LO << vt44_pkg::DATA_W;

  logic [vt44_pkg::REG_W-1:0] regs_r [vt44_pkg::NUM_REGS];
  logic [vt44_pkg::IDX_W-1:0] idx;
  logic                       wr_en;

  assign idx        = cfg_paddr[vt44_pkg::IDX_LSB +: vt44_pkg::IDX_W];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = regs_r[idx];

  // reset to identity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[vt44_pkg::REG_MAT_01]   <= ONE_LO;
      regs_r[vt44_pkg::REG_MAT_23]   <= '0;
      regs_r[vt44_pkg::REG_MAT_45]   <= ONE_HI;
      regs_r[vt44_pkg::REG_MAT_67]   <= '0;
      regs_r[vt44_pkg::REG_MAT_89]   <= '0;
      regs_r[vt44_pkg::REG_MAT_1011] <= ONE_LO;
      regs_r[vt44_pkg::REG_MAT_1213] <= '0;
      regs_r[vt44_pkg::REG_MAT_1415] <= ONE_HI;
    end else if (wr_en) begin
      regs_r[idx] <= cfg_pwdata;
    end
  end

  always_comb begin
    for (int k = 0; k < vt44_pkg::NUM_REGS; k++) begin
      mat[2*k]   = regs_r[k][vt44_pkg::DATA_W-1:0];
      mat[2*k+1] = regs_r[k][vt44_pkg::REG_W-1:vt44_pkg::DATA_W];
    end
  end

endmodule

// ===== hdl/vt44_mul_stage.sv =====
// Stage 1: picks w (point mode) and registers the sixteen 32x32 products.
// Depends on vt44_pkg.
module vt44_mul_stage #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vt44_pkg::stg_fwd_t  up_fwd,
  output vt44_pkg::stg_bwd_t  up_bwd,
  input  vt44_pkg::vt_in_t    in_beat,
  input  vt44_pkg::mat_t      mat,
  output vt44_pkg::stg_fwd_t  dn_fwd,
  input  vt44_pkg::stg_bwd_t  dn_bwd,
  output vt44_pkg::prod_set_t prod
);

  localparam logic [vt44_pkg::DATA_W-1:0] W_ONE =
    vt44_pkg::DATA_W'(64'd1 << FRAC_BITS);

  logic                                  valid_r;
  logic                                  en;
  logic [vt44_pkg::NUM_ROWS-1:0][vt44_pkg::DATA_W-1:0] vec;
  vt44_pkg::prod_set_t                   prod_r, prod_nxt;

  assign en           = ~valid_r | dn_bwd.ready;
  assign up_bwd.ready = en;
  assign dn_fwd.valid = valid_r;
  assign prod         = prod_r;

  always_comb begin
    vec[0] = in_beat.vec_x;
    vec[1] = in_beat.vec_y;
    vec[2] = in_beat.vec_z;
    vec[3] = in_beat.point_mode ? W_ONE : in_beat.vec_w;
    for (int r = 0; r < vt44_pkg::NUM_ROWS; r++) begin
      for (int c = 0; c < vt44_pkg::NUM_ROWS; c++) begin
        prod_nxt[r][c] = $signed(mat[r + vt44_pkg::NUM_ROWS*c]) * $signed(vec[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_fwd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_fwd.valid) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ===== hdl/vt44_sum_stage.sv =====
// Stage 2: exact row sums of the four products, two guard bits.
// Depends on vt44_pkg.
module vt44_sum_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  vt44_pkg::stg_fwd_t  up_fwd,
  output vt44_pkg::stg_bwd_t  up_bwd,
  input  vt44_pkg::prod_set_t prod,
  output vt44_pkg::stg_fwd_t  dn_fwd,
  input  vt44_pkg::stg_bwd_t  dn_bwd,
  output vt44_pkg::sum_set_t  sums
);

  logic               valid_r;
  logic               en;
  vt44_pkg::sum_set_t sums_r, sums_nxt;

  assign en           = ~valid_r | dn_bwd.ready;
  assign up_bwd.ready = en;
  assign dn_fwd.valid = valid_r;
  assign sums         = sums_r;

  always_comb begin
    for (int r = 0; r < vt44_pkg::NUM_ROWS; r++) begin
      sums_nxt[r] = '0;
      for (int c = 0; c < vt44_pkg::NUM_ROWS; c++) begin
        sums_nxt[r] = sums_nxt[r] +
          {{2{prod[r][c][vt44_pkg::PROD_W-1]}}, prod[r][c]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_fwd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_fwd.valid) begin
      sums_r <= sums_nxt;
    end
  end

endmodule

// ===== hdl/vt44_sat_stage.sv =====
// Stage 3: floor shift by FRAC_BITS, clip to 32 bits, output register.
// Depends on vt44_pkg.
module vt44_sat_stage #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vt44_pkg::stg_fwd_t up_fwd,
  output vt44_pkg::stg_bwd_t up_bwd,
  input  vt44_pkg::sum_set_t sums,
  output logic               out_valid,
  input  logic               out_stall,
  output vt44_pkg::vt_out_t  out_data
);

  localparam int unsigned SW = vt44_pkg::SUM_W;
  localparam int unsigned DW = vt44_pkg::DATA_W;

  logic                                       valid_r;
  logic                                       en;
  logic [vt44_pkg::NUM_ROWS-1:0][DW-1:0]      res;
  logic [vt44_pkg::NUM_ROWS-1:0]              clip;
  logic [SW-1:0]                              shf;
  vt44_pkg::vt_out_t                          data_r, data_nxt;

  assign en           = ~valid_r | ~out_stall;
  assign up_bwd.ready = en;
  assign out_valid    = valid_r;
  assign out_data     = data_r;

  always_comb begin
    shf = '0;
    for (int r = 0; r < vt44_pkg::NUM_ROWS; r++) begin
      shf = SW'($signed(sums[r]) >>> FRAC_BITS);
      // in range only when all bits above the result's sign bit match it
      clip[r] = ~((&shf[SW-1:DW-1]) | ~(|shf[SW-1:DW-1]));
      if (!clip[r]) begin
        res[r] = shf[DW-1:0];
      end else if (shf[SW-1]) begin
        res[r] = {1'b1, {(DW-1){1'b0}}};
      end else begin
        res[r] = {1'b0, {(DW-1){1'b1}}};
      end
    end
    data_nxt.out_x     = res[0];
    data_nxt.out_y     = res[1];
    data_nxt.out_z     = res[2];
    data_nxt.out_w     = res[3];
    data_nxt.saturated = |clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_fwd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_fwd.valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== hdl/vertex_transform_4x4_core.sv =====
// Channel | dir | handshake            | payload
// in      | in  | in_valid / in_stall  | in_data  (vt44_pkg::vt_in_t)
// out     | out | out_valid / out_stall| out_data (vt44_pkg::vt_out_t)
// cfg     | in  | APB psel/penable     | 64-bit matrix registers at 8*i
//
// One beat per cycle sustained while out is not stalled; each beat is registered in turn by product, row sum and clip.
// The 32x32 multipliers of stage 1 set the clock; each stage holds its own beat.
// Synchronous active-low reset empties the pipe and loads the identity matrix.
// A stall on out holds stages that are full; empty stages keep filling.
// Top level of the 4x4 vertex transform; depends on vt44_pkg and the vt44_* stages.
module vertex_transform_4x4_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  vt44_pkg::vt_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output vt44_pkg::vt_out_t            out_data,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [vt44_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [vt44_pkg::REG_W-1:0]   cfg_pwdata,
  output logic [vt44_pkg::REG_W-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  vt44_pkg::mat_t      mat;
  vt44_pkg::prod_set_t prod;
  vt44_pkg::sum_set_t  sums;
  vt44_pkg::stg_fwd_t  in_fwd, mul_fwd, sum_fwd;
  vt44_pkg::stg_bwd_t  in_bwd, mul_bwd, sum_bwd;

  assign in_fwd.valid = in_valid;
  assign in_stall     = ~in_bwd.ready;

  vt44_cfg_regs #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mat         (mat)
  );

  vt44_mul_stage #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_fwd  (in_fwd),
    .up_bwd  (in_bwd),
    .in_beat (in_data),
    .mat     (mat),
    .dn_fwd  (mul_fwd),
    .dn_bwd  (mul_bwd),
    .prod    (prod)
  );

  vt44_sum_stage u_sum (
    .clk    (clk),
    .rst_n  (rst_n),
    .up_fwd (mul_fwd),
    .up_bwd (mul_bwd),
    .prod   (prod),
    .dn_fwd (sum_fwd),
    .dn_bwd (sum_bwd),
    .sums   (sums)
  );

  vt44_sat_stage #(.FRAC_BITS(FRAC_BITS)) u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_fwd    (sum_fwd),
    .up_bwd    (sum_bwd),
    .sums      (sums),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
